### rtl/stra_pkg.sv
// Shared types, constants and the node compare function for the segment tree block.
// No dependencies; imported by segment_tree_range_argmax.
package stra_pkg;

  localparam int unsigned DefLeafCount = 1024;

  localparam int unsigned DigitW = 4;
  localparam int unsigned PosW   = 10;

  // Code held in the digit field of a node that holds nothing (one below digit zero).
  localparam logic [DigitW-1:0] EmptyDigit = 4'hF;
  localparam logic [DigitW-1:0] MaxDigit   = 4'd9;

  // One tree node: 14 bits, digit in the upper bits.
  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic [PosW-1:0]   pos;
  } node_t;

  localparam node_t EmptyNode = '{digit: EmptyDigit, pos: '0};

  // Returns the winner of two nodes: the larger digit, then the smaller position.
  // An empty node loses to any node that holds a digit.
  function automatic node_t node_better(input node_t a, input node_t b);
    logic b_wins;
    b_wins = 1'b0;
    if (b.digit != EmptyDigit) begin
      if (a.digit == EmptyDigit) begin
        b_wins = 1'b1;
      end else if (a.digit != b.digit) begin
        b_wins = (b.digit > a.digit);
      end else begin
        b_wins = (b.pos < a.pos);
      end
    end
    return b_wins ? b : a;
  endfunction

endpackage

### rtl/segment_tree_range_argmax.sv
// Range maximum with leftmost position, kept in a binary segment tree in one memory.
// Depends on stra_pkg for the node type, the empty code and the compare function.
//
// Usage: each request on the slave stream is a leaf write (tuser = 0) or a range
// query (tuser = 1). Every request gives exactly one response on the master stream.
// A write stores a digit (saturated at nine) at one leaf and rebuilds its ancestors;
// its response is all zeros. A query returns the largest digit in an inclusive leaf
// range and the leftmost leaf holding it, with tuser = 1 when the range held a digit.
// Requests are handled one at a time. For a write, the block stores the leaf, then
// walks up to the root: the walk up reads one sibling per level and writes the parent
// in the same cycle. After the root is written, the response is registered and the
// block returns to idle. A query walks at most log2(LEAF_COUNT) + 1 levels, one per
// cycle, reading both boundary nodes through the two read ports and merging them in
// the next cycle; after the final merge, the output step registers its response.
// A query with an empty range, or a write past the last leaf, goes straight to the output
// step. After reset the block sweeps the whole memory to empty, one node per cycle;
// s_axis_tready stays low during that pass.
// A finished response waits in an output register. While the receiver stalls, the
// block still accepts the next request and works on it; it only holds when a second
// response is ready before the first has been taken.
module segment_tree_range_argmax
  import stra_pkg::*;
#(
  parameter int unsigned LEAF_COUNT = DefLeafCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: position[9:0], digit_value[13:10], range_low[23:14],
  // range_high[33:24], zero padding[39:34].
  input  logic [39:0] s_axis_tdata,
  // Fields from bit 0: func (0 writes a leaf, 1 queries a range).
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: max_digit[3:0], max_position[13:4], zero padding[15:14].
  output logic [15:0] m_axis_tdata,
  // Fields from bit 0: found.
  output logic        m_axis_tuser
);

  // Node index width, and a one bit wider width for range bounds that reach 2*LEAF_COUNT.
  localparam int unsigned AW = $clog2(2 * LEAF_COUNT);
  localparam int unsigned IW = AW + 1;
  localparam logic [AW-1:0] LastNode = AW'(2 * LEAF_COUNT - 1);
  localparam logic [IW-1:0] LeafBase = IW'(LEAF_COUNT);
  localparam logic [IW-1:0] LeafLast = IW'(LEAF_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WUP,
    ST_QRY,
    ST_DONE
  } state_e;

  // Request fields.
  logic              in_func;
  logic [PosW-1:0]   in_pos;
  logic [DigitW-1:0] in_digit;
  logic [PosW-1:0]   in_lo;
  logic [PosW-1:0]   in_hi;

  assign in_func  = s_axis_tuser;
  assign in_pos   = s_axis_tdata[9:0];
  assign in_digit = s_axis_tdata[13:10];
  assign in_lo    = s_axis_tdata[23:14];
  assign in_hi    = s_axis_tdata[33:24];

  // Tree storage: one write port, two registered read ports.
  node_t             mem [2 * LEAF_COUNT];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  node_t             mem_wdata;
  logic [AW-1:0]     raddr0;
  logic [AW-1:0]     raddr1;
  node_t             rd0_q;
  node_t             rd1_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd0_q <= mem[raddr0];
    rd1_q <= mem[raddr1];
  end

  // Control and datapath registers.
  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     cur_node_q, cur_node_d;
  node_t             cur_val_q, cur_val_d;
  logic [IW-1:0]     l_q, l_d;
  logic [IW-1:0]     r_q, r_d;
  logic              use_l_q, use_l_d;
  logic              use_r_q, use_r_d;
  logic              pend_q, pend_d;
  node_t             best_q, best_d;
  logic              m_valid_q, m_valid_d;
  logic [15:0]       m_data_q, m_data_d;
  logic              m_user_q, m_user_d;

  logic              accept;
  logic              pos_ok;
  logic              lo_ok;
  logic              hi_over;
  logic [IW-1:0]     pos_ext;
  logic [IW-1:0]     lo_ext;
  logic [IW-1:0]     hi_ext;
  logic [IW-1:0]     hi_clamp;
  logic [IW-1:0]     leaf_idx;
  logic [IW-1:0]     r_minus1;
  logic [AW-1:0]     parent;
  node_t             sib_left;
  node_t             sib_right;
  node_t             merged;
  node_t             pick_l;
  node_t             pick_r;
  logic              out_free;
  logic              res_found;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Range checks use the full field width, so a small tree never sees an aliased index.
  assign pos_ok   = (32'(in_pos) < LEAF_COUNT);
  assign lo_ok    = (32'(in_lo) < LEAF_COUNT);
  assign hi_over  = (32'(in_hi) >= LEAF_COUNT);

  assign pos_ext  = IW'(in_pos);
  assign lo_ext   = IW'(in_lo);
  assign hi_ext   = IW'(in_hi);
  assign hi_clamp = hi_over ? LeafLast : hi_ext;
  assign leaf_idx = LeafBase + pos_ext;
  assign r_minus1 = r_q - IW'(1);

  // Walk up: the register holds the node on the path, memory gives its sibling.
  assign parent    = cur_node_q >> 1;
  assign sib_left  = cur_node_q[0] ? rd0_q : cur_val_q;
  assign sib_right = cur_node_q[0] ? cur_val_q : rd0_q;
  assign merged    = node_better(sib_left, sib_right);

  assign pick_l = use_l_q ? rd0_q : EmptyNode;
  assign pick_r = use_r_q ? rd1_q : EmptyNode;

  assign res_found = (best_q.digit != EmptyDigit);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cur_node_d = cur_node_q;
    cur_val_d  = cur_val_q;
    l_d        = l_q;
    r_d        = r_q;
    use_l_d    = use_l_q;
    use_r_d    = use_r_q;
    pend_d     = pend_q;
    best_d     = best_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_q;
    mem_wdata  = EmptyNode;
    raddr0     = cur_node_q ^ AW'(1);
    raddr1     = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == LastNode) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          best_d = EmptyNode;
          pend_d = 1'b0;
          if (!in_func) begin
            if (pos_ok) begin
              // Store the saturated digit at the leaf and fetch its sibling.
              cur_node_d       = leaf_idx[AW-1:0];
              cur_val_d.digit  = (in_digit > MaxDigit) ? MaxDigit : in_digit;
              cur_val_d.pos    = in_pos;
              mem_we           = 1'b1;
              mem_waddr        = leaf_idx[AW-1:0];
              mem_wdata        = cur_val_d;
              raddr0           = leaf_idx[AW-1:0] ^ AW'(1);
              state_d          = ST_WUP;
            end else begin
              state_d = ST_DONE;
            end
          end else if (!lo_ok || (lo_ext > hi_clamp)) begin
            state_d = ST_DONE;
          end else begin
            l_d     = LeafBase + lo_ext;
            r_d     = LeafBase + hi_clamp + IW'(1);
            state_d = ST_QRY;
          end
        end
      end
      ST_WUP: begin
        mem_we     = 1'b1;
        mem_waddr  = parent;
        mem_wdata  = merged;
        cur_node_d = parent;
        cur_val_d  = merged;
        raddr0     = parent ^ AW'(1);
        if (parent == AW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_QRY: begin
        if (pend_q) begin
          best_d = node_better(node_better(best_q, pick_l), pick_r);
        end
        if (l_q < r_q) begin
          // Issue both boundary reads for this level; merge them next cycle.
          raddr0  = l_q[AW-1:0];
          raddr1  = r_minus1[AW-1:0];
          use_l_d = l_q[0];
          use_r_d = r_q[0];
          l_d     = (l_q + IW'(l_q[0])) >> 1;
          r_d     = r_q >> 1;
          pend_d  = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = res_found;
          m_data_d  = res_found ? {2'b00, best_q.pos, best_q.digit} : '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      pend_q     <= 1'b0;
      m_valid_q  <= 1'b0;
      cur_node_q <= '0;
      cur_val_q  <= EmptyNode;
      l_q        <= '0;
      r_q        <= '0;
      use_l_q    <= 1'b0;
      use_r_q    <= 1'b0;
      best_q     <= EmptyNode;
      m_data_q   <= '0;
      m_user_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      pend_q     <= pend_d;
      m_valid_q  <= m_valid_d;
      cur_node_q <= cur_node_d;
      cur_val_q  <= cur_val_d;
      l_q        <= l_d;
      r_q        <= r_d;
      use_l_q    <= use_l_d;
      use_r_q    <= use_r_d;
      best_q     <= best_d;
      m_data_q   <= m_data_d;
      m_user_q   <= m_user_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // A response without a digit carries all zeros.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'h0000))
    else $error("response without a digit carries nonzero data");

  // A reported digit never exceeds nine.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[3:0] <= 4'd9))
    else $error("reported digit above nine");

  // The parent written during the walk up is never the node read in the same cycle.
  a_wup_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WUP) |-> (mem_we && (mem_waddr != raddr0)))
    else $error("walk-up write collides with the sibling read");

  // A query finishes only after its last pending read has been merged.
  a_qry_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QRY && pend_q) |=> (state_q == ST_QRY))
    else $error("query left before merging pending reads");

endmodule

### sim/tb_segment_tree_range_argmax.sv
// Self-checking testbench for segment_tree_range_argmax: leaf writes and range queries
// are driven on the request stream and each response is checked against a tree model.
// Depends on stra_pkg and segment_tree_range_argmax from the rtl folder.
`timescale 1ns / 100ps

module tb_segment_tree_range_argmax;

  localparam int unsigned LeafCount = stra_pkg::DefLeafCount;
  localparam int unsigned MaxPos    = LeafCount - 1;

  // Request kind as carried on s_axis_tuser.
  typedef enum bit {
    OpWrite = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef struct {
    op_e        op;
    logic [9:0] position;
    logic [3:0] digit;
    logic [9:0] range_lo;
    logic [9:0] range_hi;
  } tree_request_t;

  typedef struct {
    bit         found;
    logic [3:0] max_digit;
    logic [9:0] max_pos;
  } argmax_response_t;

  // Model node: an empty flag instead of the block's reserved digit code.
  typedef struct {
    bit         full;
    logic [3:0] digit;
    logic [9:0] pos;
  } tree_node_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // Fields from bit 0: position[9:0], digit_value[13:10], range_low[23:14],
  // range_high[33:24], zero padding[39:34].
  logic [39:0] s_axis_tdata;
  // Fields from bit 0: func.
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // Fields from bit 0: max_digit[3:0], max_position[13:4], zero padding[15:14].
  logic [15:0] m_axis_tdata;
  // Fields from bit 0: found.
  logic        m_axis_tuser;

  tree_request_t    pending_requests[$];
  argmax_response_t expected_responses[$];
  tree_node_t       tree_nodes[2*LeafCount];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  bit          s_fire        = 1'b0;

  segment_tree_range_argmax #(
    .LEAF_COUNT(LeafCount)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The larger digit wins, then the smaller position; an empty node always loses.
  function automatic tree_node_t pick_winner(tree_node_t a, tree_node_t b);
    if (!b.full) return a;
    if (!a.full) return b;
    if (a.digit != b.digit) return (b.digit > a.digit) ? b : a;
    return (b.pos < a.pos) ? b : a;
  endfunction

  // Applies one request to the model tree and returns the response it must produce.
  function automatic argmax_response_t predict_argmax(tree_request_t req);
    argmax_response_t rsp;
    tree_node_t       best;
    int unsigned      idx;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      l;
    int unsigned      r;
    rsp  = '{found: 1'b0, max_digit: '0, max_pos: '0};
    best = '{full: 1'b0, digit: '0, pos: '0};
    if (req.op == OpWrite) begin
      if (req.position < LeafCount) begin
        idx = LeafCount + req.position;
        tree_nodes[idx].full  = 1'b1;
        tree_nodes[idx].digit = (req.digit > stra_pkg::MaxDigit) ? stra_pkg::MaxDigit
                                                                 : req.digit;
        tree_nodes[idx].pos   = req.position;
        // Rebuild every ancestor up to the root.
        idx = idx >> 1;
        while (idx >= 1) begin
          tree_nodes[idx] = pick_winner(tree_nodes[2*idx], tree_nodes[2*idx+1]);
          idx = idx >> 1;
        end
      end
      return rsp;
    end
    lo = req.range_lo;
    hi = req.range_hi;
    if (lo >= LeafCount) return rsp;
    if (hi >= LeafCount) hi = MaxPos;
    if (lo > hi) return rsp;
    // Bottom-up walk over the half-open leaf interval [lo, hi+1).
    l = LeafCount + lo;
    r = LeafCount + hi + 1;
    while (l < r) begin
      if (l[0]) begin
        best = pick_winner(best, tree_nodes[l]);
        l++;
      end
      if (r[0]) begin
        r--;
        best = pick_winner(best, tree_nodes[r]);
      end
      l = l >> 1;
      r = r >> 1;
    end
    if (best.full) begin
      rsp.found     = 1'b1;
      rsp.max_digit = best.digit;
      rsp.max_pos   = best.pos;
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
    error_count++;
  endtask

  task automatic push_write(int unsigned pos, int unsigned dig,
                            int unsigned rlo, int unsigned rhi);
    pending_requests.push_back('{op: OpWrite, position: pos[9:0], digit: dig[3:0],
                                 range_lo: rlo[9:0], range_hi: rhi[9:0]});
  endtask

  task automatic push_query(int unsigned lo, int unsigned hi,
                            int unsigned pos, int unsigned dig);
    pending_requests.push_back('{op: OpQuery, position: pos[9:0], digit: dig[3:0],
                                 range_lo: lo[9:0], range_hi: hi[9:0]});
  endtask

  // Random mix of writes and queries. Writes lean toward a small window so that
  // equal digits compete there; queries cover small, wide, full and reversed ranges.
  task automatic queue_random_requests(int unsigned count);
    int unsigned pos;
    int unsigned dig;
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pos = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63) : $urandom_range(0, MaxPos);
        dig = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
        push_write(pos, dig, $urandom_range(0, MaxPos), $urandom_range(0, MaxPos));
      end else begin
        pick = $urandom_range(0, 99);
        lo = $urandom_range(0, MaxPos);
        if (pick < 10) begin
          lo = $urandom_range(1, MaxPos);
          hi = $urandom_range(0, lo - 1);
        end else if (pick < 20) begin
          lo = 0;
          hi = MaxPos;
        end else if (pick < 45) begin
          hi = lo + $urandom_range(0, 3);
        end else if (pick < 70) begin
          lo = $urandom_range(0, 63);
          hi = lo + $urandom_range(0, 63);
        end else begin
          hi = lo + $urandom_range(0, MaxPos);
        end
        if (hi > MaxPos) hi = MaxPos;
        push_query(lo, hi, $urandom_range(0, MaxPos), $urandom_range(0, 15));
      end
    end
  endtask

  // Holds the stimulus until every queued request is accepted and answered.
  task automatic wait_until_drained();
    do begin
      @(negedge clk_i);
      #1;
    end while (pending_requests.size() != 0 || s_axis_tvalid ||
               expected_responses.size() != 0);
  endtask

  // Driver: presents a new request only when the slot is free, then holds it
  // until the block takes it. Both sides idle at the current random rates.
  always @(negedge clk_i) begin : request_driver
    tree_request_t req;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_fire) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, req.range_hi, req.range_lo, req.digit, req.position};
          s_axis_tuser  <= req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each taken response against the oldest prediction, then
  // predicts for a request accepted at this same edge.
  always @(posedge clk_i) begin : response_monitor
    argmax_response_t want;
    tree_request_t    req;
    if (!rst_ni) begin
      s_fire = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("response with none outstanding, tdata", 0, m_axis_tdata);
        end else begin
          want = expected_responses.pop_front();
          if (m_axis_tuser !== want.found)
            report_mismatch("found", want.found, m_axis_tuser);
          if (m_axis_tdata[3:0] !== want.max_digit)
            report_mismatch("max_digit", want.max_digit, m_axis_tdata[3:0]);
          if (m_axis_tdata[13:4] !== want.max_pos)
            report_mismatch("max_position", want.max_pos, m_axis_tdata[13:4]);
        end
      end
      s_fire = s_axis_tvalid && s_axis_tready;
      if (s_fire) begin
        req.op       = op_e'(s_axis_tuser);
        req.position = s_axis_tdata[9:0];
        req.digit    = s_axis_tdata[13:10];
        req.range_lo = s_axis_tdata[23:14];
        req.range_hi = s_axis_tdata[33:24];
        expected_responses.push_back(predict_argmax(req));
      end
    end
  end

  initial begin
    foreach (tree_nodes[i]) tree_nodes[i] = '{full: 1'b0, digit: '0, pos: '0};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // First phase: the sender idles a quarter of the time, the receiver most of it.
    send_idle_pct = 25;
    recv_idle_pct = 61;

    // Directed requests: empty tree, field extremes, saturation, ties, rewrites,
    // reversed and single-leaf ranges, and unused fields set to all ones.
    push_query(0, MaxPos, 0, 0);
    push_write(0, 0, 0, 0);
    push_query(0, 0, 0, 0);
    push_write(MaxPos, 9, 0, 0);
    push_write(512, 15, 0, 0);
    push_query(0, MaxPos, 0, 0);
    push_write(100, 9, MaxPos, MaxPos);
    push_query(0, MaxPos, 0, 0);
    push_write(100, 3, 0, 0);
    push_query(0, MaxPos, 0, 0);
    push_query(513, MaxPos, 0, 0);
    push_query(MaxPos, 0, 0, 0);
    push_query(600, 600, 0, 0);
    push_write(700, 10, 0, 0);
    push_query(513, MaxPos - 1, 0, 0);
    push_query(1, 511, MaxPos, 15);
    push_write(1, 0, 0, 0);
    push_query(0, 1, 0, 0);
    push_query(MaxPos, MaxPos, 0, 0);
    push_write(10'h2AA, 5, 10'h155, 10'h2AA);
    push_query(10'h155, MaxPos, 10'h155, 10);
    queue_random_requests(360);
    wait_until_drained();

    // Second phase: the idle rates swap sides.
    send_idle_pct = 61;
    recv_idle_pct = 25;
    queue_random_requests(380);
    wait_until_drained();

    // Third phase: both sides run flat out.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_requests(390);
    wait_until_drained();

    // Let the clock run on to catch any stray response.
    repeat (40) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
rtl/stra_pkg.sv
rtl/segment_tree_range_argmax.sv
sim/tb_segment_tree_range_argmax.sv
